>>> hdl/cdu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cosine distance unit.
package cdu_pkg;

  localparam int ElemW  = 16;
  localparam int DotW   = 42;
  localparam int NormW  = 41;
  localparam int DistW  = 18;
  localparam int QueueDepth = 2;
  localparam logic [DistW-1:0] OneQ16 = 18'd65536;

  typedef struct packed {
    logic signed [DotW-1:0] dot;
    logic [NormW-1:0]       na;
    logic [NormW-1:0]       nb;
  } sums_t;

  typedef struct packed {
    logic  push;
    sums_t data;
  } push_t;

endpackage

>>> hdl/cdu_front.sv
`timescale 1ns / 1ps
// Front end: accepts element pairs and keeps the saturating running sums.
module cdu_front
  import cdu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [ElemW-1:0] elem_a,
  input  logic signed [ElemW-1:0] elem_b,
  input  logic                    last,
  input  logic                    q_full,
  output push_t                   push_o
);

  sums_t sums;
  sums_t sums_next;
  logic signed [2*ElemW-1:0] prod_ab;
  logic signed [2*ElemW-1:0] prod_aa;
  logic signed [2*ElemW-1:0] prod_bb;
  logic signed [DotW:0]      dsum;
  logic [NormW:0]            asum;
  logic [NormW:0]            bsum;
  logic                      accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    prod_ab = elem_a * elem_b;
    prod_aa = elem_a * elem_a;
    prod_bb = elem_b * elem_b;
    dsum = (DotW+1)'(sums.dot) + (DotW+1)'(prod_ab);
    asum = {1'b0, sums.na} + (NormW+1)'(prod_aa[2*ElemW-2:0]);
    bsum = {1'b0, sums.nb} + (NormW+1)'(prod_bb[2*ElemW-2:0]);
    if (dsum[DotW] != dsum[DotW-1]) begin
      sums_next.dot = dsum[DotW] ? {1'b1, {(DotW-1){1'b0}}} : {1'b0, {(DotW-1){1'b1}}};
    end else begin
      sums_next.dot = dsum[DotW-1:0];
    end
    sums_next.na = asum[NormW] ? {NormW{1'b1}} : asum[NormW-1:0];
    sums_next.nb = bsum[NormW] ? {NormW{1'b1}} : bsum[NormW-1:0];
  end

  assign push_o.push = accept && last;
  assign push_o.data = sums_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
    end else if (accept) begin
      sums <= last ? '0 : sums_next;
    end
  end

endmodule

>>> hdl/cdu_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of finished sums between front and back.
module cdu_queue
  import cdu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push_i,
  input  logic  pop,
  output logic  full,
  output logic  nonempty,
  output sums_t head
);

  sums_t       store [QueueDepth];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign head     = store[rptr];

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      store[wptr] <= push_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push_i.push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push_i.push) - 2'(pop);
    end
  end

endmodule

>>> hdl/cdu_back.sv
`timescale 1ns / 1ps
// Back end: root of the norm product, division and the result register.
module cdu_back
  import cdu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  sums_t            head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DistW-1:0] distance,
  output logic             zero_vector
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_NORM = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_SQRT = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t           state;
  logic [NormW-1:0] na;
  logic [NormW-1:0] nb;
  logic [3:0]       sh;
  logic [DotW-1:0]  mag;
  logic             neg;
  logic [63:0]      sv;
  logic [63:0]      root;
  logic [63:0]      bitv;
  logic [5:0]       cnt;
  logic [59:0]      drem;
  logic [59:0]      dsor;
  logic [17:0]      quo;
  logic [63:0]      trial;
  logic             shift_a;
  logic             shift_b;
  logic [17:0]      qc;

  assign pop       = (state == S_IDLE) && q_nonempty;
  assign out_valid = state == S_DONE;
  assign trial     = root + bitv;
  assign shift_a   = na[NormW-1:32] != '0;
  assign shift_b   = nb[NormW-1:32] != '0;
  assign qc        = (quo > 18'(OneQ16)) ? 18'(OneQ16) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_nonempty) begin
            na  <= head.na;
            nb  <= head.nb;
            sh  <= '0;
            neg <= head.dot[DotW-1];
            mag <= head.dot[DotW-1] ? DotW'(-head.dot) : DotW'(head.dot);
            if (head.na == '0 || head.nb == '0) begin
              distance    <= OneQ16;
              zero_vector <= 1'b1;
              state       <= S_DONE;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (shift_a) na <= na >> 2;
          if (shift_b) nb <= nb >> 2;
          sh <= sh + 4'(shift_a) + 4'(shift_b);
          if (!shift_a && !shift_b) state <= S_MUL;
        end
        S_MUL: begin
          sv    <= na[31:0] * nb[31:0];
          root  <= '0;
          bitv  <= 64'h4000_0000_0000_0000;
          cnt   <= 6'd31;
          dsor  <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sv >= trial) begin
            sv   <= sv - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt - 6'd1;
          if (cnt == '0) begin
            drem  <= 60'(mag) << 16;
            quo   <= '0;
            cnt   <= 6'd17;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == 6'd17 && dsor == '0) begin
            dsor <= 60'(root[32:0]) << (6'(sh) + 6'd17);
          end else begin
            if (drem >= dsor) begin
              drem <= drem - dsor;
              quo  <= {quo[16:0], 1'b1};
            end else begin
              quo <= {quo[16:0], 1'b0};
            end
            dsor <= dsor >> 1;
            cnt  <= cnt - 6'd1;
            if (cnt == '0) state <= S_FIN;
          end
        end
        S_FIN: begin
          distance    <= neg ? OneQ16 + qc : OneQ16 - qc;
          zero_vector <= 1'b0;
          state       <= S_DONE;
        end
        S_DONE: begin
          dsor <= '0;
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/cosine_distance_unit.sv
`timescale 1ns / 1ps
// Flow: each element pair updates the running sums; a vector's result follows its last pair
// through take, norm scaling, multiply, 32-step root, divide and result, or goes from take
// straight to the result register when a norm is zero.
// Throughput: one element pair per cycle while the two-entry sums queue has room; the
// serial root and divide in the back end bound the rate of vectors, not of elements.
// Reset: synchronous rst clears the sums, the queue and the back end; no result pending.
module cosine_distance_unit
  import cdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // elem_a [15:0], elem_b [31:16]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // distance [17:0], zero pad [23:18]
  output logic        m_tuser    // zero_vector
);

  push_t            push;
  logic             q_full;
  logic             q_nonempty;
  logic             pop;
  sums_t            head;
  logic [DistW-1:0] distance;

  cdu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .elem_a   (s_tdata[15:0]),
    .elem_b   (s_tdata[31:16]),
    .last     (s_tlast),
    .q_full   (q_full),
    .push_o   (push)
  );

  cdu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_i   (push),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head)
  );

  cdu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_nonempty  (q_nonempty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .distance    (distance),
    .zero_vector (m_tuser)
  );

  assign m_tdata = {6'd0, distance};

`ifndef ASSERT_OFF
  a_zero_is_one: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> distance == OneQ16)
    else $error("zero norm result is not 1.0");
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> distance <= 18'd131072)
    else $error("distance above 2.0");
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push.push)
    else $error("request pushed into full queue");
`endif

endmodule

>>> tb/tb_cosine_distance_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cosine distance unit: stimulus table, random vectors, predictor.
module tb_cosine_distance_unit;
  import cdu_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int HoldCycles = 600;

  typedef struct {
    logic [DistW-1:0] distance;
    logic             zero_vector;
  } cosine_result_t;

  typedef struct {
    logic signed [ElemW-1:0] a;
    logic signed [ElemW-1:0] b;
    logic                    last;
    logic                    typed;
    logic [DistW-1:0]        distance;
    logic                    zero_vector;
  } pair_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;

  cosine_result_t pending_results[$];
  longint          dot_acc;
  longint unsigned norm_a_acc;
  longint unsigned norm_b_acc;
  int              fails;
  int              cycles;
  bit              send_idle;
  bit              recv_idle;
  bit              hold_req;

  cosine_distance_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // advance the running sums; on a last pair, form the distance and clear
  function automatic bit accumulate_pair(logic signed [ElemW-1:0] a, logic signed [ElemW-1:0] b,
                                         logic last, output cosine_result_t res);
    longint          av;
    longint          bv;
    longint          d;
    longint unsigned na;
    longint unsigned nb;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned q;
    int              sh;
    av = a;
    bv = b;
    d = dot_acc + av * bv;
    if (d > (64'sd1 <<< 41) - 1) d = (64'sd1 <<< 41) - 1;
    if (d < -(64'sd1 <<< 41)) d = -(64'sd1 <<< 41);
    dot_acc = d;
    norm_a_acc = norm_a_acc + longint'(av * av);
    if (norm_a_acc > (64'd1 << 41) - 1) norm_a_acc = (64'd1 << 41) - 1;
    norm_b_acc = norm_b_acc + longint'(bv * bv);
    if (norm_b_acc > (64'd1 << 41) - 1) norm_b_acc = (64'd1 << 41) - 1;
    if (!last) return 1'b0;
    if (norm_a_acc == 0 || norm_b_acc == 0) begin
      res.distance = OneQ16;
      res.zero_vector = 1'b1;
    end else begin
      na = norm_a_acc;
      nb = norm_b_acc;
      sh = 0;
      while ((na >> 32) != 0) begin
        na = na >> 2;
        sh++;
      end
      while ((nb >> 32) != 0) begin
        nb = nb >> 2;
        sh++;
      end
      den = int_sqrt(na * nb) << sh;
      mag = (dot_acc < 0) ? longint'(-dot_acc) : longint'(dot_acc);
      q = (den != 0) ? ((mag << 16) / den) : 64'd65536;
      if (q > 64'd65536) q = 64'd65536;
      res.distance = (dot_acc < 0) ? DistW'(64'd65536 + q) : DistW'(64'd65536 - q);
      res.zero_vector = 1'b0;
    end
    dot_acc = 0;
    norm_a_acc = 0;
    norm_b_acc = 0;
    return 1'b1;
  endfunction

  task automatic send_pair(logic signed [ElemW-1:0] a, logic signed [ElemW-1:0] b, logic last,
                           bit typed = 1'b0, cosine_result_t typed_res = '{default: 0});
    int             gap;
    cosine_result_t res;
    gap = send_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, a};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    if (accumulate_pair(a, b, last, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  function automatic logic signed [ElemW-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      3: return ElemW'($urandom_range(0, 255)) - 16'sd128;
      default: return ElemW'($urandom);
    endcase
  endfunction

  // result side: draw a stall per request, honour the long hold-off
  initial begin
    int gap;
    cosine_result_t want;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) recv_idle = !recv_idle;
      gap = recv_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_results.size() == 0) begin
        $error("unexpected result: distance %0d zero_vector %0b", m_tdata[DistW-1:0], m_tuser);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[DistW-1:0] !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, m_tdata[DistW-1:0]);
          fails++;
        end
        if (m_tuser !== want.zero_vector) begin
          $error("zero_vector: expected %0b, got %0b", want.zero_vector, m_tuser);
          fails++;
        end
      end
    end
  end

  initial begin
    pair_row_t pair_table[$];
    cosine_result_t typed_res;
    int sent;
    int len;
    int mode;
    logic signed [ElemW-1:0] a;
    logic signed [ElemW-1:0] b;
    fails = 0;
    cycles = 0;
    dot_acc = 0;
    norm_a_acc = 0;
    norm_b_acc = 0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_req = 1'b0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    pair_table = '{
      '{16'sd0, 16'sd0, 1'b1, 1'b1, OneQ16, 1'b1},
      '{16'sd32767, 16'sd32767, 1'b1, 1'b1, 18'd0, 1'b0},
      '{16'sd32767, -16'sd32768, 1'b1, 1'b1, 18'd131072, 1'b0},
      '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, 18'd0, 1'b0},
      '{16'sd0, 16'sd5, 1'b1, 1'b1, OneQ16, 1'b1},
      '{-16'sd7, 16'sd0, 1'b1, 1'b1, OneQ16, 1'b1},
      '{16'sd1, 16'sd0, 1'b0, 1'b0, 18'd0, 1'b0},
      '{16'sd0, 16'sd1, 1'b1, 1'b1, OneQ16, 1'b0},
      '{16'sd1, 16'sd1, 1'b0, 1'b0, 18'd0, 1'b0},
      '{-16'sd1, -16'sd1, 1'b1, 1'b1, 18'd0, 1'b0},
      '{16'sd12000, -16'sd300, 1'b0, 1'b0, 18'd0, 1'b0},
      '{-16'sd32768, 16'sd32767, 1'b0, 1'b0, 18'd0, 1'b0},
      '{16'sd4096, 16'sd20000, 1'b1, 1'b0, 18'd0, 1'b0},
      '{16'sd1, -16'sd1, 1'b1, 1'b1, 18'd131072, 1'b0},
      '{16'sd3, 16'sd4, 1'b0, 1'b0, 18'd0, 1'b0},
      '{16'sd4, -16'sd3, 1'b1, 1'b1, OneQ16, 1'b0},
      '{-16'sd21846, 16'sd9, 1'b1, 1'b0, 18'd0, 1'b0}
    };
    foreach (pair_table[i]) begin
      typed_res.distance = pair_table[i].distance;
      typed_res.zero_vector = pair_table[i].zero_vector;
      send_pair(pair_table[i].a, pair_table[i].b, pair_table[i].last, pair_table[i].typed,
                typed_res);
    end

    // long vectors of extremes, both signs of the dot sum
    for (int i = 0; i < 150; i++) send_pair(-16'sd32768, -16'sd32768, i == 149);
    for (int i = 0; i < 150; i++) send_pair(-16'sd32768, 16'sd32767, i == 149);

    // fill the sums queue against a stalled result side
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_pair(pick_elem(), pick_elem(), 1'b1);
    s_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);

    sent = 0;
    while (sent < 600) begin
      if ($urandom_range(0, 7) == 0) send_idle = !send_idle;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      mode = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        a = pick_elem();
        case (mode)
          0: b = a;
          1: b = -a;
          2: b = (i % 2) ? '0 : pick_elem();
          default: b = pick_elem();
        endcase
        send_pair(a, b, i == len - 1);
        sent++;
      end
      if ($urandom_range(0, 99) == 0) begin
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
      end
    end
    s_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> cosine_distance_unit.f
hdl/cdu_pkg.sv
hdl/cdu_front.sv
hdl/cdu_queue.sv
hdl/cdu_back.sv
hdl/cosine_distance_unit.sv
tb/tb_cosine_distance_unit.sv
